@@ hdl/integer_to_roman_numeral_symbols_top_defines.svh @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: assertion macros
// Shared macros for the concurrent checks on the block's ports.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ROMAN_NUMERAL_SYMBOLS_TOP_DEFINES_SVH
`define INTEGER_TO_ROMAN_NUMERAL_SYMBOLS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define ITRN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during rst.
`define ITRN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/itrn_pkg.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: package
// Types, symbol codes and decoding functions shared by the block's modules.
// ---------------------------------------------------------------------------
package itrn_pkg;

  localparam int VALUE_W    = 16;
  localparam int SYMBOL_W   = 14;
  localparam int VALUE_BITS = 12;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int DIGITS     = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'd3999;

  localparam logic [SYMBOL_W-1:0] SYM_NONE = 14'h0000;
  localparam logic [SYMBOL_W-1:0] SYM_I    = 14'h2160;
  localparam logic [SYMBOL_W-1:0] SYM_V    = 14'h2164;
  localparam logic [SYMBOL_W-1:0] SYM_X    = 14'h2169;
  localparam logic [SYMBOL_W-1:0] SYM_L    = 14'h216C;
  localparam logic [SYMBOL_W-1:0] SYM_C    = 14'h216D;
  localparam logic [SYMBOL_W-1:0] SYM_D    = 14'h216E;
  localparam logic [SYMBOL_W-1:0] SYM_M    = 14'h216F;

  localparam logic [1:0] DEC_ONES      = 2'd0;
  localparam logic [1:0] DEC_TENS      = 2'd1;
  localparam logic [1:0] DEC_HUNDREDS  = 2'd2;
  localparam logic [1:0] DEC_THOUSANDS = 2'd3;

  typedef logic [SYMBOL_W-1:0] sym_t;

  typedef struct packed {
    logic                   oor;
    logic [DIGITS-1:0][3:0] digits;
  } job_t;

  // Number of symbols that one decimal digit produces.
  function automatic logic [2:0] digit_len(input logic [3:0] d);
    logic [2:0] len;
    len = 3'd0;
    unique case (d) inside
      4'd0:          len = 3'd0;
      4'd1, 4'd5:    len = 3'd1;
      4'd2, 4'd4,
      4'd6, 4'd9:    len = 3'd2;
      4'd3, 4'd7:    len = 3'd3;
      4'd8:          len = 3'd4;
      default:       len = 3'd0;
    endcase
    return len;
  endfunction

  // Symbol at position pos of the pattern for digit d in decade dec.
  function automatic sym_t roman_symbol(input logic [1:0] dec, input logic [3:0] d,
                                        input logic [1:0] pos);
    sym_t one;
    sym_t five;
    sym_t ten;
    sym_t sym;
    one  = SYM_I;
    five = SYM_V;
    ten  = SYM_X;
    unique case (dec)
      DEC_ONES:      begin one = SYM_I; five = SYM_V; ten = SYM_X; end
      DEC_TENS:      begin one = SYM_X; five = SYM_L; ten = SYM_C; end
      DEC_HUNDREDS:  begin one = SYM_C; five = SYM_D; ten = SYM_M; end
      DEC_THOUSANDS: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
      default:       begin one = SYM_I; five = SYM_V; ten = SYM_X; end
    endcase
    unique case (d) inside
      4'd4:        sym = (pos == 2'd0) ? one : five;
      4'd9:        sym = (pos == 2'd0) ? one : ten;
      [4'd5:4'd8]: sym = (pos == 2'd0) ? five : one;
      default:     sym = one;
    endcase
    return sym;
  endfunction

endpackage

@@ hdl/itrn_front.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: front end
// Accepts numbers, rejects those out of range and converts the rest to
// decimal digits with a shift-and-add-three loop, one bit per cycle.
// ---------------------------------------------------------------------------
module itrn_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itrn_pkg::VALUE_W-1:0]  value,
  output logic                          push_valid,
  input  logic                          push_ready,
  output itrn_pkg::job_t                push_job
);

  localparam logic F_IDLE = 1'b0;
  localparam logic F_CONV = 1'b1;

  logic                               state;
  logic [itrn_pkg::CNT_W-1:0]         cnt;
  logic [itrn_pkg::VALUE_BITS-1:0]    bin;
  logic [itrn_pkg::DIGITS*4-1:0]      bcd;
  logic [itrn_pkg::DIGITS*4-1:0]      bcd_corr;
  logic [itrn_pkg::DIGITS*4-1:0]      bcd_next;
  logic                               job_valid;
  itrn_pkg::job_t                     job;
  logic                               accept;
  logic                               reject;

  assign in_ready   = (state == F_IDLE) && !job_valid;
  assign accept     = in_valid && in_ready;
  assign reject     = (value == '0) || (value > itrn_pkg::VALUE_MAX);
  assign push_valid = job_valid;
  assign push_job   = job;

  always_comb begin
    for (int i = 0; i < itrn_pkg::DIGITS; i++) begin
      bcd_corr[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
    bcd_next = {bcd_corr[itrn_pkg::DIGITS*4-2:0], bin[itrn_pkg::VALUE_BITS-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= F_IDLE;
      job_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (job_valid && push_ready) begin
        job_valid <= 1'b0;
      end
      unique case (state)
        F_IDLE: begin
          if (accept) begin
            if (reject) begin
              job_valid  <= 1'b1;
              job.oor    <= 1'b1;
              job.digits <= '0;
            end else begin
              state <= F_CONV;
              cnt   <= '0;
              bin   <= value[itrn_pkg::VALUE_BITS-1:0];
              bcd   <= '0;
            end
          end
        end
        F_CONV: begin
          bcd <= bcd_next;
          bin <= {bin[itrn_pkg::VALUE_BITS-2:0], 1'b0};
          cnt <= cnt + 1'b1;
          if (cnt == itrn_pkg::CNT_W'(itrn_pkg::VALUE_BITS - 1)) begin
            state      <= F_IDLE;
            job_valid  <= 1'b1;
            job.oor    <= 1'b0;
            job.digits <= bcd_next;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/itrn_queue.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: job queue
// A short first-in first-out queue of converted numbers between the front
// end and the symbol emitter.
// ---------------------------------------------------------------------------
module itrn_queue #(
  parameter int Depth = itrn_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  itrn_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output itrn_pkg::job_t pop_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  itrn_pkg::job_t  entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (fill != CntW'(Depth));
  assign pop_valid  = (fill != '0);
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

@@ hdl/itrn_back.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: symbol emitter
// Walks the decimal digits of a queued number from its top non-zero decade
// down, one symbol per cycle into an output register unless out_ready stalls.
// ---------------------------------------------------------------------------
module itrn_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  itrn_pkg::job_t                 pop_job,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [itrn_pkg::SYMBOL_W-1:0]  symbol,
  output logic                           last,
  output logic                           out_of_range
);

  logic                        busy;
  itrn_pkg::job_t              job;
  logic [itrn_pkg::DIGITS-1:0] mask;
  logic [itrn_pkg::DIGITS-1:0] mask_clr;
  logic [1:0]                  pos;
  logic [1:0]                  cur;
  logic [3:0]                  digit;
  logic [2:0]                  len;
  logic                        fin_digit;
  logic                        is_last;
  logic                        adv;
  itrn_pkg::sym_t              sym;

  always_comb begin
    cur = itrn_pkg::DEC_ONES;
    if (mask[1]) cur = itrn_pkg::DEC_TENS;
    if (mask[2]) cur = itrn_pkg::DEC_HUNDREDS;
    if (mask[3]) cur = itrn_pkg::DEC_THOUSANDS;
  end

  assign digit     = job.digits[cur];
  assign len       = itrn_pkg::digit_len(digit);
  assign sym       = itrn_pkg::roman_symbol(cur, digit, pos);
  assign fin_digit = ({1'b0, pos} == (len - 3'd1));
  assign mask_clr  = mask & ~(itrn_pkg::DIGITS'(1) << cur);
  assign is_last   = job.oor || (fin_digit && (mask_clr == '0));
  assign adv       = !out_valid || out_ready;
  assign pop_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      pos       <= '0;
      mask      <= '0;
    end else begin
      if (!busy && pop_valid) begin
        busy <= 1'b1;
        job  <= pop_job;
        pos  <= '0;
        for (int i = 0; i < itrn_pkg::DIGITS; i++) begin
          mask[i] <= (pop_job.digits[i] != 4'd0);
        end
      end
      if (adv) begin
        out_valid <= busy;
        if (busy) begin
          symbol       <= job.oor ? itrn_pkg::SYM_NONE : sym;
          last         <= is_last;
          out_of_range <= job.oor;
          if (is_last) begin
            busy <= 1'b0;
          end else if (fin_digit) begin
            mask <= mask_clr;
            pos  <= '0;
          end else begin
            pos <= pos + 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hdl/integer_to_roman_numeral_symbols_top.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: top level
// Converts each accepted number from 1 to 3999 into its Roman numeral as a
// run of Unicode number-form symbols, most significant first, with the final
// symbol marked; other numbers give one transaction with out_of_range set.
// ---------------------------------------------------------------------------
// A number is accepted by the front end, converted bit-serially from binary
// to decimal and handed to a short queue, where it waits; a rejected number
// skips the conversion. The emitter then loads each number and delivers one
// symbol per cycle unless out_ready stalls the output register. The front
// end takes no new number until the current one is in the queue, but it can
// convert the next one while the emitter still delivers an earlier one.
module integer_to_roman_numeral_symbols_top #(
  parameter int QueueDepth = itrn_pkg::QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [itrn_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [itrn_pkg::SYMBOL_W-1:0] symbol,
  output logic                          last,
  output logic                          out_of_range
);

  logic           push_valid;
  logic           push_ready;
  itrn_pkg::job_t push_job;
  logic           pop_valid;
  logic           pop_ready;
  itrn_pkg::job_t pop_job;

  itrn_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  itrn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  itrn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_job      (pop_job),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .symbol       (symbol),
    .last         (last),
    .out_of_range (out_of_range)
  );

endmodule

@@ hdl/itrn_checker.sv @@
// ---------------------------------------------------------------------------
// Integer to Roman numeral symbols: port checker
// Concurrent checks on the output transactions seen at the top level's ports.
// ---------------------------------------------------------------------------
`include "integer_to_roman_numeral_symbols_top_defines.svh"

module itrn_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [itrn_pkg::VALUE_W-1:0]  value,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [itrn_pkg::SYMBOL_W-1:0] symbol,
  input logic                          last,
  input logic                          out_of_range
);

  logic in_seen;

  assign in_seen = in_valid && in_ready && (value != '0);

`ITRN_ASSERT_IMP(a_oor_is_last, out_valid && out_of_range, last && (symbol == itrn_pkg::SYM_NONE), "rejected number must give a single empty transaction")
`ITRN_ASSERT_IMP(a_symbol_legal, out_valid && !out_of_range, (symbol == itrn_pkg::SYM_I) || (symbol == itrn_pkg::SYM_V) || (symbol == itrn_pkg::SYM_X) || (symbol == itrn_pkg::SYM_L) || (symbol == itrn_pkg::SYM_C) || (symbol == itrn_pkg::SYM_D) || (symbol == itrn_pkg::SYM_M), "symbol is not a Roman numeral code point")
`ITRN_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(symbol) && $stable(last) && $stable(out_of_range), "stalled output transaction changed")
`ITRN_ASSERT_NXT(a_in_busy, in_seen && (value <= itrn_pkg::VALUE_MAX), !in_ready, "front end took a new number during conversion")

endmodule

bind integer_to_roman_numeral_symbols_top itrn_checker u_itrn_checker (.*);
